// File: rtl/rmst_pkg.sv
// Shared types and constants for the range-minimum segment tree.
package rmst_pkg;

    localparam int DEFAULT_LEAVES = 1024;

    localparam int FIRST_W   = 10;
    localparam int LAST_W    = 11;
    localparam int VALUE_W   = 64;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 64;

    // Item kinds carried on s_tuser.
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Empty-node value and the largest signed value.
    localparam logic signed [VALUE_W-1:0] SENTINEL = 64'sd1000000000000000;
    localparam logic signed [VALUE_W-1:0] MAX_VALUE = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic                      action;
        logic [FIRST_W-1:0]        first;
        logic [LAST_W-1:0]         last_excl;
        logic signed [VALUE_W-1:0] value;
    } rmst_item_t;

endpackage

// File: rtl/rmst_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rmst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/rmst_walker.sv
// Tree walker: clearing pass, leaf update with ancestor refresh, range query.
module rmst_walker #(
    parameter int LEAVES = rmst_pkg::DEFAULT_LEAVES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rmst_pkg::rmst_item_t                item,
    output logic                                res_valid,
    output logic signed [rmst_pkg::VALUE_W-1:0] res_data,
    input  logic                                out_free,
    output logic                                mem_we,
    output logic [$clog2(LEAVES):0]             mem_waddr,
    output logic [rmst_pkg::VALUE_W-1:0]        mem_wdata,
    output logic [$clog2(LEAVES):0]             mem_raddr,
    input  logic [rmst_pkg::VALUE_W-1:0]        mem_rdata
);
    import rmst_pkg::*;

    localparam int LOG_L = $clog2(LEAVES);
    localparam int AW    = LOG_L + 1;
    localparam int NW    = LOG_L + 2;
    localparam int CW    = (NW > 12) ? NW : 12;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_UPW   = 3'd3;
    localparam logic [2:0] ST_QWALK = 3'd4;
    localparam logic [2:0] ST_QLAST = 3'd5;
    localparam logic [2:0] ST_QOUT  = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic [AW-1:0]             clr_reg, clr_next;
    logic [AW-1:0]             k_reg, k_next;
    logic signed [VALUE_W-1:0] cur_reg, cur_next;
    logic [NW-1:0]             l_reg, l_next;
    logic [NW-1:0]             r_reg, r_next;
    logic signed [VALUE_W-1:0] res_reg, res_next;
    logic                      pend_reg, pend_next;

    logic [CW-1:0]             lo_w, hi_w, lv_w, hi_c;
    logic                      q_empty, q_full, upd_ok;
    logic [CW-1:0]             l_sum, r_sum;
    logic signed [VALUE_W-1:0] rd_s, res_acc, upd_min;
    logic [AW-1:0]             parent;
    logic [NW-1:0]             r_dec;

    assign rd_s = mem_rdata;

    // Clamp the query range to the leaves that exist.
    always_comb begin
        lo_w    = CW'(item.first);
        hi_w    = CW'(item.last_excl);
        lv_w    = CW'(LEAVES);
        hi_c    = (hi_w > lv_w) ? lv_w : hi_w;
        q_empty = (lo_w >= hi_c);
        q_full  = (lo_w == '0) && (hi_w >= lv_w);
        upd_ok  = (lo_w < lv_w);
        l_sum   = lo_w + lv_w;
        r_sum   = hi_c + lv_w;
    end

    assign res_acc = (pend_reg && (rd_s < res_reg)) ? rd_s : res_reg;
    assign upd_min = (rd_s < cur_reg) ? rd_s : cur_reg;
    assign parent  = k_reg >> 1;
    assign r_dec   = r_reg - NW'(1);

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        k_next     = k_reg;
        cur_next   = cur_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        res_next   = res_acc;
        pend_next  = 1'b0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = cur_reg;
        mem_raddr  = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = SENTINEL;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(2 * LEAVES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (item.action == ACT_QUERY) begin
                        state_next = ST_QWALK;
                        res_next   = q_full ? MAX_VALUE : SENTINEL;
                        if (q_empty) begin
                            l_next = '0;
                            r_next = '0;
                        end else begin
                            l_next = l_sum[NW-1:0];
                            r_next = r_sum[NW-1:0];
                        end
                    end else if (upd_ok) begin
                        state_next = ST_UPD;
                        k_next     = l_sum[AW-1:0];
                        cur_next   = item.value;
                    end
                end
            end
            ST_UPD: begin
                // write the leaf, fetch its sibling
                mem_we     = 1'b1;
                mem_waddr  = k_reg;
                mem_wdata  = cur_reg;
                mem_raddr  = k_reg ^ AW'(1);
                state_next = ST_UPW;
            end
            ST_UPW: begin
                // refresh the parent, fetch the parent's sibling
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = upd_min;
                mem_raddr = parent ^ AW'(1);
                cur_next  = upd_min;
                k_next    = parent;
                if (parent == AW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QWALK: begin
                if (l_reg >= r_reg) begin
                    state_next = ST_QLAST;
                end else if (l_reg[0]) begin
                    mem_raddr = l_reg[AW-1:0];
                    pend_next = 1'b1;
                    l_next    = l_reg + NW'(1);
                end else if (r_reg[0]) begin
                    mem_raddr = r_dec[AW-1:0];
                    pend_next = 1'b1;
                    l_next    = l_reg >> 1;
                    r_next    = r_dec >> 1;
                end else begin
                    l_next = l_reg >> 1;
                    r_next = r_reg >> 1;
                end
            end
            ST_QLAST: begin
                state_next = ST_QOUT;
            end
            ST_QOUT: begin
                res_valid = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_data = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
        end
        k_reg   <= k_next;
        cur_reg <= cur_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        res_reg <= res_next;
    end

    a_walk_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_QWALK |-> l_reg <= r_reg)
        else $error("query bounds crossed");

    a_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD || state_reg == ST_UPW) |-> mem_waddr != mem_raddr)
        else $error("read and write hit the same node");

    a_query_ro: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QWALK || state_reg == ST_QLAST || state_reg == ST_QOUT)
        |-> !mem_we)
        else $error("query wrote the tree");

    a_pend_src: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(state_reg) == ST_QWALK)
        else $error("pending read without a walk step");

endmodule

// File: rtl/range_min_segment_tree.sv
// Range-minimum segment tree: stream ports, result register and node memory.
// Update: after accept, write the leaf, then refresh one parent per cycle up to the root.
// Query: walk from the leaves toward the root, at most two node reads per level
// through the single read port of the node memory.
// One item at a time; the next is taken the cycle after a result loads, even while it waits.
// After reset a clearing pass writes 10^15 into 2*LEAVES entries, one per cycle;
// s_tready stays low until it completes.
module range_min_segment_tree #(
    parameter int LEAVES = rmst_pkg::DEFAULT_LEAVES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first [9:0], last_excl [20:10], value [84:21], zero pad [87:85]
    input  logic [rmst_pkg::S_TDATA_W-1:0]   s_tdata,
    // action [0]
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // minimum [63:0]
    output logic [rmst_pkg::M_TDATA_W-1:0]   m_tdata
);
    import rmst_pkg::*;

    localparam int AW = $clog2(LEAVES) + 1;

    rmst_item_t                item;
    logic                      res_valid;
    logic signed [VALUE_W-1:0] res_data;
    logic                      out_free;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr, mem_raddr;
    logic [VALUE_W-1:0]        mem_wdata, mem_rdata;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;

    // Unpack the input item.
    always_comb begin
        item.action    = s_tuser[0];
        item.first     = s_tdata[FIRST_W-1:0];
        item.last_excl = s_tdata[FIRST_W+LAST_W-1:FIRST_W];
        item.value     = s_tdata[FIRST_W+LAST_W+VALUE_W-1:FIRST_W+LAST_W];
    end

    rmst_walker #(
        .LEAVES(LEAVES)
    ) u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .item     (item),
        .res_valid(res_valid),
        .res_data (res_data),
        .out_free (out_free),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    // Node store: heap order, root at address 1, leaf p at LEAVES+p.
    rmst_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(2 * LEAVES)
    ) u_nodes (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Result register: load when empty or being drained, hold otherwise.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'(res_data);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: verif/range_min_segment_tree_tb.sv
// Self-checking testbench for the range-minimum segment tree, with its own tree predictor.
module range_min_segment_tree_tb;

    import rmst_pkg::*;

    localparam int LEAVES     = DEFAULT_LEAVES;
    localparam int NODES      = 2 * LEAVES - 1;
    // Leave generous slack at the end, after the last query walk.
    localparam int SETTLE_CYC = 60;
    // Slowest correct run: ~800 items, a long hold-off and the clearing pass,
    // taken several times over.
    localparam int LIMIT_CYC  = 500000;
    localparam int HOLD_CYC   = 300;
    localparam logic signed [VALUE_W-1:0] MIN_VALUE = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // first [9:0], last_excl [20:10], value [84:21], pad
    logic [0:0]            s_tuser;   // action [0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // minimum [63:0]

    // Predicted node store and the minima still owed by the block.
    logic signed [VALUE_W-1:0] seg_nodes [0:NODES-1];
    logic signed [VALUE_W-1:0] expected_minima [$];
    logic signed [VALUE_W-1:0] want;

    int       failures;
    int       n_updates;
    int       n_queries;
    int       n_results;
    int       burst_left;
    bit       sender_bursty;
    rx_mode_t rx_mode;
    int       hold_cycles;
    int       rx_phase;

    range_min_segment_tree #(
        .LEAVES(LEAVES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Minimum over [lo, hi) as seen from node idx covering [nl, nr).
    function automatic logic signed [VALUE_W-1:0] covered_min(input int lo, input int hi,
                                                             input int idx, input int nl,
                                                             input int nr);
        int mid;
        logic signed [VALUE_W-1:0] left_min;
        logic signed [VALUE_W-1:0] right_min;
        if (nr <= lo || hi <= nl) return SENTINEL;
        if (lo <= nl && nr <= hi) return seg_nodes[idx];
        mid       = (nl + nr) / 2;
        left_min  = covered_min(lo, hi, 2 * idx + 1, nl, mid);
        right_min = covered_min(lo, hi, 2 * idx + 2, mid, nr);
        return (left_min < right_min) ? left_min : right_min;
    endfunction

    // Leaf values weighted toward the extremes and the sentinel.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return $signed(64'($urandom_range(0, 2000))) - 64'sd1000;
            2: return MAX_VALUE;
            3: return MIN_VALUE;
            4: return SENTINEL + $signed(64'($urandom_range(0, 4))) - 64'sd2;
            default: return -$signed({1'b0, 31'($urandom), $urandom});
        endcase
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10) $display("[%0t] %s", $realtime, msg);
    endtask

    // Offer one item, hold it until accepted, then advance the predictor.
    task automatic send_item(input logic act, input logic [FIRST_W-1:0] lo,
                             input logic [LAST_W-1:0] hi, input logic signed [VALUE_W-1:0] v);
        int gap;
        int node;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 5);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, v, hi, lo};
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (act == ACT_UPDATE) begin
            n_updates++;
            if (int'(lo) < LEAVES) begin
                node = int'(lo) + LEAVES - 1;
                seg_nodes[node] = v;
                while (node > 0) begin
                    node = (node - 1) / 2;
                    seg_nodes[node] = (seg_nodes[2*node+1] < seg_nodes[2*node+2]) ?
                                      seg_nodes[2*node+1] : seg_nodes[2*node+2];
                end
            end
        end else begin
            n_queries++;
            expected_minima = {expected_minima,
                               covered_min(int'(lo), int'(hi), 0, 0, LEAVES)};
        end
    endtask

    // Drop valid and hold until every owed minimum has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_minima.size() != 0) @(posedge aclk);
    endtask

    task automatic test_fresh_tree();
        send_item(ACT_QUERY, 10'd0,   11'd1024, pick_value());  // root of a cleared tree
        send_item(ACT_QUERY, 10'd0,   11'd2047, pick_value());  // bound past the last leaf
        send_item(ACT_QUERY, 10'd5,   11'd5,    pick_value());  // empty range
        send_item(ACT_QUERY, 10'd700, 11'd3,    pick_value());  // reversed bounds
    endtask

    task automatic test_extremes();
        send_item(ACT_UPDATE, 10'd0,    11'd0,    MAX_VALUE);
        send_item(ACT_UPDATE, 10'd1023, 11'd2047, MIN_VALUE);
        send_item(ACT_UPDATE, 10'd512,  11'd0,    64'sd0);
        send_item(ACT_UPDATE, 10'd513,  11'h7FF,  -64'sd1);
        send_item(ACT_UPDATE, 10'd100,  11'd0,    SENTINEL + 64'sd1);
        send_item(ACT_QUERY,  10'd0,    11'd1,    64'sd0);
        send_item(ACT_QUERY,  10'd1023, 11'd2047, {$urandom, $urandom});
        send_item(ACT_QUERY,  10'd0,    11'd1024, 64'sd0);
        send_item(ACT_QUERY,  10'd512,  11'd514,  64'sd0);
        send_item(ACT_QUERY,  10'd100,  11'd101,  64'sd0);   // single leaf above the sentinel
        send_item(ACT_QUERY,  10'd101,  11'd512,  64'sd0);   // only untouched leaves
        send_item(ACT_QUERY,  10'd1023, 11'd1023, 64'sd0);
        send_item(ACT_QUERY,  10'd0,    11'd0,    64'sd0);
        send_item(ACT_UPDATE, 10'd1023, 11'd0,    SENTINEL + 64'sd5);
        send_item(ACT_QUERY,  10'd0,    11'd2047, 64'sd0);
        send_item(ACT_QUERY,  10'd514,  11'd1024, 64'sd0);
    endtask

    // Mixed updates and queries, partly clustered on a moving window so queries see fresh leaves.
    task automatic test_random_mix(input int chunks);
        int c;
        int i;
        int base;
        int lo;
        int hi;
        for (c = 0; c < chunks; c++) begin
            base          = $urandom_range(0, LEAVES - 48);
            sender_bursty = (c == 0) ? 1'b1 : bit'($urandom_range(0, 3) != 0);
            rx_mode       = (c == 0) ? RX_RANDOM : rx_mode_t'($urandom_range(0, 2));
            for (i = 0; i < 50; i++) begin
                if ($urandom_range(0, 99) < 45) begin
                    lo = ($urandom_range(0, 1) != 0) ? base + $urandom_range(0, 31)
                                                     : $urandom_range(0, LEAVES - 1);
                    send_item(ACT_UPDATE, 10'(lo), 11'($urandom), pick_value());
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin
                            lo = base + $urandom_range(0, 31);
                            hi = lo + $urandom_range(0, 16);
                        end
                        1: begin
                            lo = $urandom_range(0, LEAVES - 1);
                            hi = $urandom_range(0, 2 * LEAVES - 1);
                        end
                        2: begin
                            lo = $urandom_range(0, LEAVES - 1);
                            hi = $urandom_range(LEAVES, 2 * LEAVES - 1);
                        end
                        default: begin
                            lo = $urandom_range(0, LEAVES - 1);
                            hi = $urandom_range(0, lo);
                        end
                    endcase
                    send_item(ACT_QUERY, 10'(lo), 11'(hi), {$urandom, $urandom});
                end
            end
        end
    endtask

    // Stall the result side for a long stretch while queries keep coming.
    task automatic test_backpressure();
        int i;
        sender_bursty = 1'b0;
        rx_mode       = RX_ALWAYS;
        hold_cycles   = HOLD_CYC;
        for (i = 0; i < 10; i++) begin
            send_item(ACT_QUERY, 10'($urandom_range(0, LEAVES - 1)),
                      11'($urandom_range(0, 2 * LEAVES - 1)), pick_value());
        end
    endtask

    // Pause the sender until the block has drained, then resume.
    task automatic test_drain_pause();
        int i;
        sender_bursty = 1'b1;
        rx_mode       = RX_PATTERN;
        for (i = 0; i < 20; i++) begin
            if (i == 10) wait_for_results();
            if (i % 2 == 0)
                send_item(ACT_UPDATE, 10'($urandom), 11'($urandom), pick_value());
            else
                send_item(ACT_QUERY, 10'($urandom_range(0, 200)),
                          11'($urandom_range(100, 1100)), pick_value());
        end
    endtask

    // Result side: long hold-off first, else the current stall pattern.
    initial begin
        m_tready <= 1'b0;
        rx_phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                    default:    m_tready <= ((rx_phase % 7) < 3);
                endcase
            end
            rx_phase++;
        end
    end

    // Compare each accepted minimum with the oldest owed one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_minima.size() == 0) begin
                note_failure($sformatf("unexpected result %0d", $signed(m_tdata)));
            end else begin
                want = expected_minima.pop_front();
                if ($signed(m_tdata) !== want)
                    note_failure($sformatf("minimum mismatch: expected %0d, got %0d",
                                           want, $signed(m_tdata)));
            end
        end
    end

    initial begin
        repeat (LIMIT_CYC) @(posedge aclk);
        $display("Timeout after %0d cycles", LIMIT_CYC);
        $display("FAIL");
        $finish;
    end

    initial begin
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= ACT_UPDATE;
        aresetn       <= 1'b0;
        failures      = 0;
        n_updates     = 0;
        n_queries     = 0;
        n_results     = 0;
        burst_left    = 0;
        hold_cycles   = 0;
        sender_bursty = 1'b1;
        rx_mode       = RX_RANDOM;
        for (int n = 0; n < NODES; n++) seg_nodes[n] = SENTINEL;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_fresh_tree();
        test_extremes();
        test_random_mix(15);
        test_backpressure();
        test_drain_pause();

        wait_for_results();
        repeat (SETTLE_CYC) @(posedge aclk);
        $display("Sent %0d updates and %0d range queries; %0d minima checked.",
                 n_updates, n_queries, n_results);
        $display("Covered extreme values, empty, reversed and oversized ranges, long stalls.");
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("%0d failures", failures);
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/rmst_pkg.sv
rtl/rmst_ram.sv
rtl/rmst_walker.sv
rtl/range_min_segment_tree.sv
verif/range_min_segment_tree_tb.sv
